>>> design/ihcv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ihcv_pkg
// shared constants and the byte-wide crc-32 step for the image header checker
// ----------------------------------------------------------------------------
package ihcv_pkg;

    // header layout: magic, payload length, expected crc, little-endian words
    localparam int unsigned HEADER_BYTES = 12;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

    // verdict codes
    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd3;

    // register indexes on the config port
    localparam logic REG_EXPECTED_MAGIC = 1'b0;
    localparam logic REG_MAX_PAYLOAD_LEN = 1'b1;

    typedef logic [31:0] crc_t;

    // reflected crc-32, one byte, eight bit steps unrolled
    function automatic crc_t crc32_byte(input crc_t crc_in, input logic [7:0] data);
        crc_t c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> design/image_header_crc_validator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_header_crc_validator
// checks magic, payload length and crc-32 of an image arriving as a byte stream
// ----------------------------------------------------------------------------
// The block takes one image byte per request and sustains one request per clock
// cycle unless a stalled verdict holds the input. Each request passes an input
// register, then header capture or a byte-wide reflected crc-32 step, and lands
// in a result register, which holds the verdict once the request completes the
// header or payload. A request with start_req high begins a new image, dropping
// any image in progress. After the 12 header bytes (magic, payload length,
// expected crc, each little-endian) a bad magic is reported first, then a
// length of zero or above max_payload_len; otherwise the crc runs over exactly
// the payload length and the verdict is ok or crc mismatch. computed_crc is
// zero for header verdicts. Bytes after a verdict are dropped until the next
// start. Configuration registers: expected_magic at 0x0, max_payload_len at
// 0x4 (paddr[2] selects, low bits ignored); write them only while idle.
// ----------------------------------------------------------------------------
module image_header_crc_validator
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        start_req,
    input  wire logic [7:0]  data_byte,

    // verdict channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      computed_crc,

    // apb config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // image phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    localparam logic [31:0] HDR_LAST = 32'(ihcv_pkg::HEADER_BYTES - 1);

    // config registers
    logic [31:0] expected_magic_reg;
    logic [31:0] max_payload_len_reg;

    // input register
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_start_reg;
    logic [7:0]  s1_byte_reg;

    // image state
    logic [1:0]         phase_reg, phase_next;
    logic [31:0]        byte_count_reg, byte_count_next;
    logic [31:0]        header_magic_reg, header_magic_next;
    logic [31:0]        payload_length_reg, payload_length_next;
    logic [31:0]        header_crc_reg, header_crc_next;
    ihcv_pkg::crc_t     running_crc_reg, running_crc_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] computed_crc_reg, computed_crc_next;

    logic        out_free;
    logic        proc;
    logic        in_accept;
    logic        cfg_write;

    // working values for the byte in the input register
    logic [1:0]         phase_eff;
    logic [31:0]        count_eff;
    logic [31:0]        count_inc;
    logic [1:0]         lane;
    ihcv_pkg::crc_t     crc_step;
    logic [31:0]        crc_final;

    // ------------------------------------------------------------------------
    // config port: always ready, no wait states
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_magic_reg  <= '0;
            max_payload_len_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                ihcv_pkg::REG_EXPECTED_MAGIC:  expected_magic_reg  <= pwdata;
                ihcv_pkg::REG_MAX_PAYLOAD_LEN: max_payload_len_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ihcv_pkg::REG_EXPECTED_MAGIC:  prdata = expected_magic_reg;
            ihcv_pkg::REG_MAX_PAYLOAD_LEN: prdata = max_payload_len_reg;
            default:                       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // flow control: the byte in the input register is processed only when the
    // result register can take a verdict, so the image state never runs ahead
    // of an unread verdict
    // ------------------------------------------------------------------------
    assign out_free  = !out_valid_reg || !out_stall;
    assign proc      = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next = in_accept ? 1'b1 : (proc ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_start_reg <= start_req;
            s1_byte_reg  <= data_byte;
        end
    end

    // ------------------------------------------------------------------------
    // per-byte processing
    // ------------------------------------------------------------------------
    // a start byte is header byte zero whatever the phase was
    assign phase_eff = s1_start_reg ? PH_HEADER : phase_reg;
    assign count_eff = s1_start_reg ? 32'd0 : byte_count_reg;
    assign count_inc = count_eff + 32'd1;
    assign lane      = count_eff[1:0];
    assign crc_step  = ihcv_pkg::crc32_byte(running_crc_reg, s1_byte_reg);
    assign crc_final = crc_step ^ ihcv_pkg::CRC_XOROUT;

    always_comb
    begin
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        header_magic_next   = header_magic_reg;
        payload_length_next = payload_length_reg;
        header_crc_next     = header_crc_reg;
        running_crc_next    = running_crc_reg;
        out_valid_next      = out_valid_reg && out_stall;
        status_next         = status_reg;
        computed_crc_next   = computed_crc_reg;

        if (proc)
        begin
            unique case (phase_eff)
                PH_HEADER:
                begin
                    // every header byte lands once, so plain overwrite suffices
                    unique case (count_eff[3:2])
                        2'd0:    header_magic_next[8*lane +: 8]   = s1_byte_reg;
                        2'd1:    payload_length_next[8*lane +: 8] = s1_byte_reg;
                        2'd2:    header_crc_next[8*lane +: 8]     = s1_byte_reg;
                        default: ;
                    endcase
                    phase_next      = PH_HEADER;
                    byte_count_next = count_inc;

                    // magic and length words are complete before the last byte
                    if (count_eff == HDR_LAST)
                    begin
                        if (header_magic_reg != expected_magic_reg)
                        begin
                            phase_next        = PH_DONE;
                            out_valid_next    = 1'b1;
                            status_next       = ihcv_pkg::STATUS_BAD_MAGIC;
                            computed_crc_next = '0;
                        end
                        else if (payload_length_reg == 32'd0 ||
                                 payload_length_reg > max_payload_len_reg)
                        begin
                            phase_next        = PH_DONE;
                            out_valid_next    = 1'b1;
                            status_next       = ihcv_pkg::STATUS_BAD_LEN;
                            computed_crc_next = '0;
                        end
                        else
                        begin
                            phase_next       = PH_PAYLOAD;
                            byte_count_next  = '0;
                            running_crc_next = ihcv_pkg::CRC_INIT;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    running_crc_next = crc_step;
                    byte_count_next  = count_inc;
                    if (count_inc == payload_length_reg)
                    begin
                        phase_next        = PH_DONE;
                        out_valid_next    = 1'b1;
                        status_next       = (crc_final == header_crc_reg) ?
                                            ihcv_pkg::STATUS_OK :
                                            ihcv_pkg::STATUS_CRC_ERR;
                        computed_crc_next = crc_final;
                    end
                end
                default: ;  // idle or verdict given: byte dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            byte_count_reg     <= '0;
            header_magic_reg   <= '0;
            payload_length_reg <= '0;
            header_crc_reg     <= '0;
            running_crc_reg    <= ihcv_pkg::CRC_INIT;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            header_magic_reg   <= header_magic_next;
            payload_length_reg <= payload_length_next;
            header_crc_reg     <= header_crc_next;
            running_crc_reg    <= running_crc_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        computed_crc_reg <= computed_crc_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign computed_crc = computed_crc_reg;

endmodule
`default_nettype wire

>>> design/ihcv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ihcv_checker
// port-level checks for the image header checker
// ----------------------------------------------------------------------------
module ihcv_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  status,
    input wire logic [31:0] computed_crc
);

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(computed_crc))
        else $error("stalled verdict changed");

    // header verdicts carry no crc
    a_hdr_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ihcv_pkg::STATUS_BAD_MAGIC ||
                      status == ihcv_pkg::STATUS_BAD_LEN) |-> computed_crc == 32'd0)
        else $error("header verdict with nonzero crc");

    // a fresh verdict follows a request taken through the input and result registers
    a_verdict_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("verdict without a matching request");

endmodule

bind image_header_crc_validator ihcv_checker u_ihcv_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .computed_crc (computed_crc)
);
`default_nettype wire
